// File: rtl/nbpt_pkg.sv
// Shared types, constants and helpers of the nearest-blob puck tracker.
// No dependencies; every other file of the block imports this package.
package nbpt_pkg;

    // Default coordinate width, 0.1 mm per step
    localparam int COORD_WIDTH_DEF = 16;

    // Divider geometry: dividend/quotient width and divisor width
    localparam int DIV_W = 56;
    localparam int DEN_W = 32;

    // Velocity limits, 24 bit signed
    localparam logic signed [23:0] VEL_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] VEL_MIN = 24'sh800000;

    // Configuration register indexes
    localparam logic [1:0] CFG_RATE = 2'd0;
    localparam logic [1:0] CFG_HX   = 2'd1;
    localparam logic [1:0] CFG_HY   = 2'd2;

    // Reset values of the configuration registers
    localparam logic [15:0] RATE_RST = 16'd445;
    localparam logic [14:0] HX_RST   = 15'd5000;
    localparam logic [14:0] HY_RST   = 15'd3000;

    // Tracker modes as reported on the result
    typedef enum logic [1:0] {
        MODE_LOST    = 2'd0,
        MODE_FINDING = 2'd1,
        MODE_NORMAL  = 2'd2
    } t_mode;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic pmul;
        logic vmul;
        logic start;
        logic sel_rate;
        logic pred;
        logic sq;
        logic cmp;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic       empty;
        logic       last;
        logic       gap_zero;
        logic       div_busy;
        logic       out_busy;
        logic       valid;
        logic       step;
        logic [1:0] tally;
        t_mode      mode;
    } t_stat;

    // Saturate a rounded quotient magnitude with its sign to 24 bits
    function automatic logic signed [23:0] vel_sat(input logic [DIV_W-1:0] q,
                                                   input logic neg);
        logic signed [23:0] v;
        if (neg) begin
            if (q >= DIV_W'(24'h800000)) v = VEL_MIN;
            else v = -$signed(q[23:0]);
        end else begin
            if (q > DIV_W'(24'h7FFFFF)) v = VEL_MAX;
            else v = $signed(q[23:0]);
        end
        return v;
    endfunction

endpackage

// File: rtl/nbpt_div.sv
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
// Depends on nbpt_pkg for the dividend and divisor widths.
module nbpt_div import nbpt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_num_x,
    input  logic [DIV_W-1:0] i_num_y,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic [DIV_W-1:0] o_quo_x,
    output logic [DIV_W-1:0] o_quo_y
);
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_den;
    logic [DIV_W-1:0] r_num [2];
    logic [DEN_W-1:0] r_rem [2];
    logic [DIV_W-1:0] n_num [2];
    logic [DEN_W-1:0] n_rem [2];

    // One restoring step per lane
    always_comb begin
        logic [DEN_W:0] sh;
        for (int l = 0; l < 2; l++) begin
            sh = {r_rem[l], r_num[l][DIV_W-1]};
            if (sh >= {1'b0, r_den}) begin
                n_rem[l] = DEN_W'(sh - {1'b0, r_den});
                n_num[l] = {r_num[l][DIV_W-2:0], 1'b1};
            end else begin
                n_rem[l] = sh[DEN_W-1:0];
                n_num[l] = {r_num[l][DIV_W-2:0], 1'b0};
            end
        end
    end

    // Sequence the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DIV_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) r_busy <= 1'b0;
        end
    end

    // Load and shift the lanes
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den    <= i_den;
            r_num[0] <= i_num_x;
            r_num[1] <= i_num_y;
            r_rem[0] <= '0;
            r_rem[1] <= '0;
        end else if (r_busy) begin
            r_num[0] <= n_num[0];
            r_num[1] <= n_num[1];
            r_rem[0] <= n_rem[0];
            r_rem[1] <= n_rem[1];
        end
    end

    assign o_busy  = r_busy;
    assign o_quo_x = r_num[0];
    assign o_quo_y = r_num[1];

endmodule

// File: rtl/nbpt_dp.sv
// Datapath of the puck tracker: configuration, tracker state, products,
// shared divider, nearest-blob search and the result register.
// Depends on nbpt_pkg and nbpt_div.
module nbpt_dp import nbpt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    output t_stat                         o_stat,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [15:0]                   i_cfg_data,
    input  logic signed [COORD_WIDTH-1:0] i_blob_x,
    input  logic signed [COORD_WIDTH-1:0] i_blob_y,
    input  logic [31:0]                   i_frame_number,
    input  logic                          i_frame_empty,
    input  logic                          i_frame_last,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [COORD_WIDTH-1:0] o_pos_x,
    output logic signed [COORD_WIDTH-1:0] o_pos_y,
    output logic signed [23:0]            o_vel_x,
    output logic signed [23:0]            o_vel_y,
    output logic                          o_pos_valid,
    output logic [1:0]                    o_track_mode,
    output logic [31:0]                   o_frame_seen,
    output logic                          o_zero_gap
);
    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;
    localparam int SQW   = 2 * CW;
    localparam int SUMW  = 2 * CW + 1;
    localparam int DISTW = (SUMW > 64) ? 64 : SUMW;
    localparam int PW    = DIV_W + 2;
    localparam int BW    = CW + 16;
    localparam longint C_HI = (longint'(1) <<< (CW - 1)) - 1;
    localparam longint C_LO = -C_HI - 1;

    // Configuration
    logic [15:0] r_rate;
    logic [14:0] r_hx, r_hy;
    // Tracker state
    t_mode                r_mode;
    logic                 r_step, r_valid;
    logic signed [CW-1:0] r_est_x, r_est_y;
    logic signed [23:0]   r_spd_x, r_spd_y;
    logic [31:0]          r_prev;
    logic [1:0]           r_tally;
    logic [DISTW-1:0]     r_best;
    logic signed [CW-1:0] r_best_x, r_best_y;
    // Current item
    logic signed [CW-1:0] r_bx, r_by;
    logic [31:0]          r_fn;
    logic                 r_empty, r_last;
    // Working registers
    logic [DIV_W-1:0]     r_prod_x, r_prod_y;
    logic                 r_neg_x, r_neg_y;
    logic signed [CW-1:0] r_pred_x, r_pred_y;
    logic [SQW-1:0]       r_sq_x, r_sq_y;
    // Result register
    logic                 r_out_valid;
    logic signed [CW-1:0] r_out_px, r_out_py;
    logic signed [23:0]   r_out_vx, r_out_vy;
    logic                 r_out_pv, r_out_zg;
    logic [1:0]           r_out_md;
    logic [31:0]          r_out_fn;

    logic [15:0]      rate_eff;
    logic [31:0]      gap;
    logic             div_busy;
    logic [DIV_W-1:0] quo_x, quo_y;
    logic [DIV_W-1:0] num_x, num_y, half;
    logic [DEN_W-1:0] den;

    assign rate_eff = (r_rate == 16'd0) ? 16'd1 : r_rate;
    assign gap      = r_fn - r_prev;

    // Effective mode once the blob count of the frame is known
    t_mode eff_mode;
    logic  eff_step;
    always_comb begin
        eff_mode = r_mode;
        eff_step = r_step;
        if (r_tally != 2'd0 && r_mode == MODE_LOST) begin
            eff_mode = MODE_FINDING;
            eff_step = 1'b0;
        end else if (r_tally == 2'd0) begin
            eff_mode = MODE_LOST;
        end
    end

    // Magnitudes feeding the multipliers
    logic [23:0]          mag_sx, mag_sy;
    logic signed [DW-1:0] dif_x, dif_y;
    logic [DW-1:0]        mag_dx, mag_dy;
    assign mag_sx = r_spd_x[23] ? 24'(-r_spd_x) : 24'(r_spd_x);
    assign mag_sy = r_spd_y[23] ? 24'(-r_spd_y) : 24'(r_spd_y);
    assign dif_x  = DW'(r_best_x) - DW'(r_est_x);
    assign dif_y  = DW'(r_best_y) - DW'(r_est_y);
    assign mag_dx = dif_x[DW-1] ? DW'(-dif_x) : DW'(dif_x);
    assign mag_dy = dif_y[DW-1] ? DW'(-dif_y) : DW'(dif_y);

    // Divider operands: rounding half added to the product magnitude
    assign half  = i_cmd.sel_rate ? DIV_W'(rate_eff >> 1) : DIV_W'(gap >> 1);
    assign num_x = r_prod_x + half;
    assign num_y = r_prod_y + half;
    assign den   = i_cmd.sel_rate ? DEN_W'(rate_eff) : DEN_W'(gap);

    nbpt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_num_x (num_x),
        .i_num_y (num_y),
        .i_den   (den),
        .o_busy  (div_busy),
        .o_quo_x (quo_x),
        .o_quo_y (quo_y)
    );

    // Prediction: estimate plus signed displacement, saturated
    logic signed [PW-1:0] psum_x, psum_y;
    logic signed [CW-1:0] pred_x, pred_y;
    assign psum_x = PW'(r_est_x) + (r_neg_x ? -$signed(PW'(quo_x)) : $signed(PW'(quo_x)));
    assign psum_y = PW'(r_est_y) + (r_neg_y ? -$signed(PW'(quo_y)) : $signed(PW'(quo_y)));
    always_comb begin
        if (psum_x > $signed(PW'(C_HI)))      pred_x = CW'(C_HI);
        else if (psum_x < $signed(PW'(C_LO))) pred_x = CW'(C_LO);
        else                                  pred_x = CW'(psum_x);
        if (psum_y > $signed(PW'(C_HI)))      pred_y = CW'(C_HI);
        else if (psum_y < $signed(PW'(C_LO))) pred_y = CW'(C_LO);
        else                                  pred_y = CW'(psum_y);
    end

    // Blob offset from the prediction
    logic signed [DW-1:0] off_x, off_y;
    logic [DW-1:0]        mag_ox, mag_oy;
    assign off_x  = DW'(r_bx) - DW'(r_pred_x);
    assign off_y  = DW'(r_by) - DW'(r_pred_y);
    assign mag_ox = off_x[DW-1] ? DW'(-off_x) : DW'(off_x);
    assign mag_oy = off_y[DW-1] ? DW'(-off_y) : DW'(off_y);

    // Distance, clamped to 64 bits on the widest coordinates
    logic [SUMW-1:0]  sum_sq;
    logic [DISTW-1:0] cand_dist;
    assign sum_sq = SUMW'(r_sq_x) + SUMW'(r_sq_y);
    always_comb begin
        if (SUMW > DISTW && (sum_sq >> DISTW) != '0) cand_dist = '1;
        else cand_dist = DISTW'(sum_sq);
    end

    // Velocity candidates
    logic signed [23:0] vel_x, vel_y;
    always_comb begin
        if (gap == 32'd0) begin
            vel_x = (dif_x > 0) ? VEL_MAX : ((dif_x < 0) ? VEL_MIN : 24'sd0);
            vel_y = (dif_y > 0) ? VEL_MAX : ((dif_y < 0) ? VEL_MIN : 24'sd0);
        end else begin
            vel_x = vel_sat(quo_x, r_neg_x);
            vel_y = vel_sat(quo_y, r_neg_y);
        end
    end

    // Table limits on the extrapolated estimate
    logic [CW-1:0] mag_px, mag_py;
    logic          inside_tbl;
    assign mag_px = r_pred_x[CW-1] ? CW'(-r_pred_x) : CW'(r_pred_x);
    assign mag_py = r_pred_y[CW-1] ? CW'(-r_pred_y) : CW'(r_pred_y);
    assign inside_tbl = !(BW'(mag_px) > BW'(r_hx)) && !(BW'(mag_py) > BW'(r_hy));

    // Frame-end update of the tracker
    t_mode                n_mode;
    logic                 n_step, n_valid, n_zg;
    logic signed [CW-1:0] n_est_x, n_est_y;
    logic signed [23:0]   n_spd_x, n_spd_y;
    always_comb begin
        n_mode  = eff_mode;
        n_step  = eff_step;
        n_valid = r_valid;
        n_zg    = 1'b0;
        n_est_x = r_est_x;
        n_est_y = r_est_y;
        n_spd_x = r_spd_x;
        n_spd_y = r_spd_y;
        case (eff_mode)
            MODE_LOST: begin
                if (r_valid) begin
                    n_est_x = r_pred_x;
                    n_est_y = r_pred_y;
                    n_valid = inside_tbl;
                end
            end
            MODE_FINDING: begin
                if (r_tally == 2'd1) begin
                    n_est_x = r_best_x;
                    n_est_y = r_best_y;
                    if (!eff_step) begin
                        n_step  = 1'b1;
                        n_spd_x = '0;
                        n_spd_y = '0;
                        n_valid = 1'b1;
                    end else begin
                        n_spd_x = vel_x;
                        n_spd_y = vel_y;
                        n_zg    = (gap == 32'd0);
                        n_mode  = MODE_NORMAL;
                    end
                end else begin
                    n_mode = MODE_LOST;
                end
            end
            MODE_NORMAL: begin
                n_spd_x = vel_x;
                n_spd_y = vel_y;
                n_zg    = (gap == 32'd0);
                n_est_x = r_best_x;
                n_est_y = r_best_y;
            end
            default: n_mode = eff_mode;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RST;
            r_hx   <= HX_RST;
            r_hy   <= HY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RATE: r_rate <= i_cfg_data;
                CFG_HX:   r_hx   <= i_cfg_data[14:0];
                CFG_HY:   r_hy   <= i_cfg_data[14:0];
                default:  r_rate <= r_rate;
            endcase
        end
    end

    // Tracker state, frame search and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_LOST;
            r_step      <= 1'b0;
            r_valid     <= 1'b0;
            r_est_x     <= '0;
            r_est_y     <= '0;
            r_spd_x     <= '0;
            r_spd_y     <= '0;
            r_prev      <= '0;
            r_tally     <= '0;
            r_best      <= '1;
            r_best_x    <= '0;
            r_best_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cmp) begin
                if (cand_dist < r_best) begin
                    r_best   <= cand_dist;
                    r_best_x <= r_bx;
                    r_best_y <= r_by;
                end
                if (r_tally != 2'd2) r_tally <= r_tally + 2'd1;
            end
            if (i_cmd.commit) begin
                r_mode      <= n_mode;
                r_step      <= n_step;
                r_valid     <= n_valid;
                r_est_x     <= n_est_x;
                r_est_y     <= n_est_y;
                r_spd_x     <= n_spd_x;
                r_spd_y     <= n_spd_y;
                r_prev      <= r_fn;
                r_tally     <= '0;
                r_best      <= '1;
                r_best_x    <= '0;
                r_best_y    <= '0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bx    <= i_blob_x;
            r_by    <= i_blob_y;
            r_fn    <= i_frame_number;
            r_empty <= i_frame_empty;
            r_last  <= i_frame_last;
        end
        if (i_cmd.pmul) begin
            r_prod_x <= DIV_W'(mag_sx * gap);
            r_prod_y <= DIV_W'(mag_sy * gap);
            r_neg_x  <= r_spd_x[23];
            r_neg_y  <= r_spd_y[23];
        end else if (i_cmd.vmul) begin
            r_prod_x <= DIV_W'(mag_dx * rate_eff);
            r_prod_y <= DIV_W'(mag_dy * rate_eff);
            r_neg_x  <= dif_x[DW-1];
            r_neg_y  <= dif_y[DW-1];
        end
        if (i_cmd.pred) begin
            r_pred_x <= pred_x;
            r_pred_y <= pred_y;
        end
        if (i_cmd.sq) begin
            r_sq_x <= SQW'(mag_ox[CW-1:0] * mag_ox[CW-1:0]);
            r_sq_y <= SQW'(mag_oy[CW-1:0] * mag_oy[CW-1:0]);
        end
        if (i_cmd.commit) begin
            r_out_px <= n_est_x;
            r_out_py <= n_est_y;
            r_out_vx <= n_spd_x;
            r_out_vy <= n_spd_y;
            r_out_pv <= n_valid;
            r_out_md <= n_mode;
            r_out_fn <= r_fn;
            r_out_zg <= n_zg;
        end
    end

    assign o_stat = '{
        empty:    r_empty,
        last:     r_last,
        gap_zero: (gap == 32'd0),
        div_busy: div_busy,
        out_busy: r_out_valid && !i_out_ready,
        valid:    r_valid,
        step:     eff_step,
        tally:    r_tally,
        mode:     eff_mode
    };

    assign o_out_valid  = r_out_valid;
    assign o_pos_x      = r_out_px;
    assign o_pos_y      = r_out_py;
    assign o_vel_x      = r_out_vx;
    assign o_vel_y      = r_out_vy;
    assign o_pos_valid  = r_out_pv;
    assign o_track_mode = r_out_md;
    assign o_frame_seen = r_out_fn;
    assign o_zero_gap   = r_out_zg;

    // Never overwrite a result that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten while stalled");

    // Blob count saturates at two
    a_tally_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tally != 2'd3)
        else $error("blob count beyond two");

    // A frame end clears the per-frame search
    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_tally == 2'd0 && r_best == '1 && r_out_valid))
        else $error("frame search not cleared");

endmodule

// File: rtl/nbpt_ctrl.sv
// Controller of the puck tracker: sequences blob search and frame end.
// Depends on nbpt_pkg for command and status types.
module nbpt_ctrl import nbpt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_ROUTE  = 12'b000000000010,
        S_PMUL   = 12'b000000000100,
        S_PSTART = 12'b000000001000,
        S_PWAIT  = 12'b000000010000,
        S_PRED   = 12'b000000100000,
        S_SQ     = 12'b000001000000,
        S_CMP    = 12'b000010000000,
        S_DEC    = 12'b000100000000,
        S_VMUL   = 12'b001000000000,
        S_VSTART = 12'b010000000000,
        S_FIN    = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_end, n_end;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_end   = r_end;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_ROUTE;
                end
            end
            S_ROUTE: begin
                if (!i_stat.empty)    n_state = S_PMUL;
                else if (i_stat.last) n_state = S_DEC;
                else                  n_state = S_IDLE;
            end
            S_PMUL: begin
                o_cmd.pmul = 1'b1;
                n_state    = S_PSTART;
            end
            S_PSTART: begin
                o_cmd.start    = 1'b1;
                o_cmd.sel_rate = 1'b1;
                n_state        = S_PWAIT;
            end
            S_PWAIT: begin
                if (!i_stat.div_busy) n_state = S_PRED;
            end
            S_PRED: begin
                o_cmd.pred = 1'b1;
                n_state    = r_end ? S_FIN : S_SQ;
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = i_stat.last ? S_DEC : S_IDLE;
            end
            S_DEC: begin
                case (i_stat.mode)
                    MODE_LOST: begin
                        if (i_stat.valid) begin
                            n_end   = 1'b1;
                            n_state = S_PMUL;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    MODE_FINDING: begin
                        if (i_stat.tally == 2'd1 && i_stat.step && !i_stat.gap_zero)
                            n_state = S_VMUL;
                        else
                            n_state = S_FIN;
                    end
                    MODE_NORMAL: n_state = i_stat.gap_zero ? S_FIN : S_VMUL;
                    default:     n_state = S_FIN;
                endcase
            end
            S_VMUL: begin
                o_cmd.vmul = 1'b1;
                n_state    = S_VSTART;
            end
            S_VSTART: begin
                o_cmd.start = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                // Wait for the divider and for room in the result register
                if (!i_stat.div_busy && !i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_end        = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_end   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_end   <= n_end;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

// File: rtl/nearest_blob_puck_tracker_core.sv
// Top level of the nearest-blob puck tracker: stream ports, field packing,
// controller and datapath. Depends on nbpt_pkg, nbpt_ctrl and nbpt_dp.
//
//  channel   direction  handshake                 payload
//  s (blob)  in         i_s_tvalid / o_s_tready   tdata, tlast = last, tuser = empty
//  m (track) out        o_m_tvalid / i_m_tready   tdata, tuser = valid, mode, zero gap
//  cfg       in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A blob request waits on the shared serial divider (56 quotient bits), which
// scales speed by gap over frame rate for the prediction. A closing blob then
// runs the velocity division, unless no division is needed. An empty closing
// request runs the extrapolation division in lost mode with a valid estimate,
// else it goes straight to the frame end.
// Requests are taken one at a time; a result stalled at the output only
// holds the block when the next frame end is ready to be written.
// Reset is synchronous and clears the tracker state, the configuration and the result valid flag.
module nearest_blob_puck_tracker_core import nbpt_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // blob_x, blob_y, frame_number, zero fill (lowest bit first)
    input  logic [((2*COORD_WIDTH+32+7)/8)*8-1:0] i_s_tdata,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  logic i_s_tlast,
    // frame_empty
    input  logic i_s_tuser,
    // pos_x, pos_y, vel_x, vel_y, frame_seen, zero fill (lowest bit first)
    output logic [((2*COORD_WIDTH+80+7)/8)*8-1:0] o_m_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // pos_valid, track_mode, zero_gap (lowest bit first)
    output logic [3:0] o_m_tuser,
    input  logic i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    localparam int CW    = COORD_WIDTH;
    localparam int OUT_W = ((2*COORD_WIDTH+80+7)/8)*8;

    t_cmd  cmd;
    t_stat stat;

    logic signed [CW-1:0] pos_x, pos_y;
    logic signed [23:0]   vel_x, vel_y;
    logic                 pos_valid, zero_gap;
    logic [1:0]           track_mode;
    logic [31:0]          frame_seen;

    nbpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    nbpt_dp #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_blob_x       ($signed(i_s_tdata[CW-1:0])),
        .i_blob_y       ($signed(i_s_tdata[2*CW-1:CW])),
        .i_frame_number (i_s_tdata[2*CW+31:2*CW]),
        .i_frame_empty  (i_s_tuser),
        .i_frame_last   (i_s_tlast),
        .i_out_ready    (i_m_tready),
        .o_out_valid    (o_m_tvalid),
        .o_pos_x        (pos_x),
        .o_pos_y        (pos_y),
        .o_vel_x        (vel_x),
        .o_vel_y        (vel_y),
        .o_pos_valid    (pos_valid),
        .o_track_mode   (track_mode),
        .o_frame_seen   (frame_seen),
        .o_zero_gap     (zero_gap)
    );

    // Pack the result fields
    assign o_m_tdata = OUT_W'({frame_seen, vel_y, vel_x, pos_y, pos_x});
    assign o_m_tuser = {zero_gap, track_mode, pos_valid};

endmodule
